>>> sv/av_sync_frame_pacer_assert.svh
// assertion macros for the frame pacer block
`ifndef AV_SYNC_FRAME_PACER_ASSERT_SVH
`define AV_SYNC_FRAME_PACER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk_i, off during reset
`define AVSFP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on clk_i, off during reset
`define AVSFP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AVSFP_ASSERT_IMP(label, ante, cons, msg)
`define AVSFP_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

>>> sv/avsfp_pkg.sv
// shared types and constants of the frame pacer
package avsfp_pkg;

  localparam int TIME_W     = 48;
  localparam int DIFF_W     = TIME_W + 1;
  localparam int DUR_W      = 32;
  localparam int THR_W      = 20;
  localparam int SER_W      = 16;
  localparam int MS_W       = 39;
  localparam int QUO_W      = 38;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_TDATA_W  = 312;
  localparam int OUT_TDATA_W = 96;

  // divide by 1000 as shift by 3, then multiply by a reciprocal of 125
  localparam int X8_W    = TIME_W - 3;
  localparam int RECIP_W = 46;
  localparam int RECIP_SH = 52;
  localparam logic [RECIP_W-1:0] RECIP_125 = RECIP_W'((64'd1 << RECIP_SH) / 125 + 1);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_MIN      = 3'd0,
    REG_SYNC_MAX      = 3'd1,
    REG_FRAMEDUP      = 3'd2,
    REG_MAX_FRAME_DUR = 3'd3,
    REG_REFRESH       = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [THR_W-1:0] sync_threshold_min;
    logic [THR_W-1:0] sync_threshold_max;
    logic [THR_W-1:0] framedup_threshold;
    logic [DUR_W-1:0] frame_dur_limit;
    logic [THR_W-1:0] refresh_period;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sync_threshold_min: THR_W'(40000),
    sync_threshold_max: THR_W'(100000),
    framedup_threshold: THR_W'(100000),
    frame_dur_limit:    DUR_W'(10000000),
    refresh_period:     THR_W'(10000)
  };

  // input item, last field in the lowest bits
  typedef struct packed {
    logic [4:0]               pad;
    logic signed [TIME_W-1:0] now_time;
    logic                     clocks_valid;
    logic signed [TIME_W-1:0] audio_clock;
    logic signed [TIME_W-1:0] video_clock;
    logic                     pts_valid;
    logic [SER_W-1:0]         next_serial;
    logic signed [TIME_W-1:0] next_pts;
    logic [DUR_W-1:0]         prev_duration;
    logic [SER_W-1:0]         prev_serial;
    logic signed [TIME_W-1:0] prev_pts;
    logic                     frame_ready;
  } in_item_t;

  // result item, last field in the lowest bits
  typedef struct packed {
    logic [2:0]             pad;
    logic                   shown_time_valid;
    logic signed [MS_W-1:0] shown_time_ms;
    logic [DUR_W-1:0]       target_delay;
    logic [THR_W-1:0]       wait_us;
    logic                   advance;
  } out_item_t;

  // clock skew flags passed to the delay correction
  typedef struct packed {
    logic clocks_valid;
    logic clk_near;
  } skew_ctl_t;

endpackage

>>> sv/avsfp_skew.sv
// sync threshold and audio clock correction of the frame delay
module avsfp_skew import avsfp_pkg::*; (
  input  cfg_t                     cfg_i,
  input  logic [DUR_W-1:0]         nominal_i,
  input  logic signed [DIFF_W-1:0] clk_diff_i,
  input  skew_ctl_t                ctl_i,
  output logic [DUR_W-1:0]         delay_o
);

  logic [THR_W-1:0]         thr_lo;
  logic [THR_W-1:0]         thr;
  logic signed [DIFF_W-1:0] thr_s;
  logic                     lag;
  logic                     lead;
  logic                     long_delay;
  logic signed [DUR_W+1:0]  sum;
  logic [DUR_W:0]           dbl;
  logic [DUR_W-1:0]         sum_sat;
  logic [DUR_W-1:0]         dbl_sat;

  // threshold clamped to [min, max], min wins when they cross
  always_comb begin
    thr_lo = (nominal_i < {{(DUR_W-THR_W){1'b0}}, cfg_i.sync_threshold_max}) ?
             nominal_i[THR_W-1:0] : cfg_i.sync_threshold_max;
    thr    = (thr_lo < cfg_i.sync_threshold_min) ? cfg_i.sync_threshold_min : thr_lo;
    thr_s  = $signed({{(DIFF_W-THR_W){1'b0}}, thr});
  end

  // candidate delays; the difference is short whenever it is used
  always_comb begin
    lag        = clk_diff_i <= -thr_s;
    lead       = clk_diff_i >= thr_s;
    long_delay = nominal_i > {{(DUR_W-THR_W){1'b0}}, cfg_i.framedup_threshold};
    sum        = $signed({2'b00, nominal_i}) + $signed(clk_diff_i[DUR_W+1:0]);
    dbl        = {nominal_i, 1'b0};
    if (sum[DUR_W+1]) begin
      sum_sat = '0;
    end else if (sum[DUR_W]) begin
      sum_sat = '1;
    end else begin
      sum_sat = sum[DUR_W-1:0];
    end
    dbl_sat = dbl[DUR_W] ? '1 : dbl[DUR_W-1:0];
  end

  // pick shorten, add lead, double or keep
  always_comb begin
    delay_o = nominal_i;
    if (ctl_i.clocks_valid && ctl_i.clk_near) begin
      if (lag) begin
        delay_o = sum_sat;
      end else if (lead && long_delay) begin
        delay_o = sum_sat;
      end else if (lead) begin
        delay_o = dbl_sat;
      end
    end
  end

endmodule

>>> sv/av_sync_frame_pacer.sv
// top level of the audio/video frame pacer
// an accepted item is registered in s1_q, s2_q, s3_q, s4_q and s5_q, then offered from out_q
// throughput: one item per cycle while m_axis_tready does not hold the output; the frame
// timer loop is a single add and compare stage at the pipeline end, so items may follow back to back
// reset: pipeline and output emptied, registers take their default values,
// frame timer cleared to zero
`include "av_sync_frame_pacer_assert.svh"

module av_sync_frame_pacer import avsfp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // frame_ready, prev_pts, prev_serial, prev_duration, next_pts, next_serial,
  // pts_valid, video_clock, audio_clock, clocks_valid, now_time, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // advance, wait_us, target_delay, shown_time_ms, shown_time_valid, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  typedef struct packed {
    logic                     frame_ready;
    logic                     pts_valid;
    logic                     clocks_valid;
    logic                     ser_eq;
    logic [DUR_W-1:0]         prev_duration;
    logic signed [DIFF_W-1:0] pts_diff;
    logic signed [DIFF_W-1:0] clk_diff;
    logic signed [TIME_W-1:0] now;
    logic                     np_neg;
    logic [X8_W-1:0]          x8;
  } st2_t;

  typedef struct packed {
    logic                     frame_ready;
    logic                     pts_valid;
    skew_ctl_t                ctl;
    logic [DUR_W-1:0]         nominal;
    logic signed [DIFF_W-1:0] clk_diff;
    logic signed [TIME_W-1:0] now;
    logic                     np_neg;
    logic [42:0]              p_hh;
    logic [44:0]              p_hl;
    logic [45:0]              p_lh;
    logic [47:0]              p_ll;
  } st3_t;

  typedef struct packed {
    logic                     frame_ready;
    logic                     pts_valid;
    logic [DUR_W-1:0]         delay;
    logic signed [TIME_W-1:0] now;
    logic                     np_neg;
    logic [QUO_W-1:0]         quo;
  } st4_t;

  typedef struct packed {
    logic                     frame_ready;
    logic                     pts_valid;
    logic [DUR_W-1:0]         delay;
    logic signed [DIFF_W-1:0] dn;
    logic signed [TIME_W-1:0] now;
    logic signed [MS_W-1:0]   ms;
  } st5_t;

  cfg_t                     cfg_q;
  in_item_t                 s1_q;
  st2_t                     s2_q, s2_d;
  st3_t                     s3_q, s3_d;
  st4_t                     s4_q, s4_d;
  st5_t                     s5_q, s5_d;
  out_item_t                out_q, out_d;
  logic                     v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;
  logic                     rdy1, rdy2, rdy3, rdy4, rdy5, out_rdy;
  logic                     e_fire;
  logic signed [TIME_W-1:0] timer_q, timer_d;

  logic [TIME_W-1:0]        np_mag;
  logic [DIFF_W-1:0]        clk_mag;
  logic [91:0]              prod_sum;
  logic [DUR_W-1:0]         skew_delay;
  logic signed [49:0]       gap;
  logic [TIME_W-1:0]        due;
  logic                     not_due;
  logic                     late;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SYNC_MIN:      cfg_q.sync_threshold_min <= cfg_data_i[THR_W-1:0];
        REG_SYNC_MAX:      cfg_q.sync_threshold_max <= cfg_data_i[THR_W-1:0];
        REG_FRAMEDUP:      cfg_q.framedup_threshold <= cfg_data_i[THR_W-1:0];
        REG_MAX_FRAME_DUR: cfg_q.frame_dur_limit    <= cfg_data_i[DUR_W-1:0];
        REG_REFRESH:       cfg_q.refresh_period     <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // stage advance: a stage moves when it is empty or its successor moves
  assign out_rdy       = !out_valid_q || m_axis_tready;
  assign rdy5          = !v5_q || out_rdy;
  assign rdy4          = !v4_q || rdy5;
  assign rdy3          = !v3_q || rdy4;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign e_fire        = v5_q && out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy1)    v1_q        <= s_axis_tvalid;
      if (rdy2)    v2_q        <= v1_q;
      if (rdy3)    v3_q        <= v2_q;
      if (rdy4)    v4_q        <= v3_q;
      if (rdy5)    v5_q        <= v4_q;
      if (out_rdy) out_valid_q <= v5_q;
    end
  end

  // stage a: timestamp and clock differences, magnitude of the next pts
  always_comb begin
    np_mag = s1_q.next_pts[TIME_W-1] ? (~s1_q.next_pts + TIME_W'(1)) : s1_q.next_pts;
    s2_d.frame_ready   = s1_q.frame_ready;
    s2_d.pts_valid     = s1_q.pts_valid;
    s2_d.clocks_valid  = s1_q.clocks_valid;
    s2_d.ser_eq        = s1_q.prev_serial == s1_q.next_serial;
    s2_d.prev_duration = s1_q.prev_duration;
    s2_d.pts_diff      = $signed({s1_q.next_pts[TIME_W-1], s1_q.next_pts})
                       - $signed({s1_q.prev_pts[TIME_W-1], s1_q.prev_pts});
    s2_d.clk_diff      = $signed({s1_q.video_clock[TIME_W-1], s1_q.video_clock})
                       - $signed({s1_q.audio_clock[TIME_W-1], s1_q.audio_clock});
    s2_d.now           = s1_q.now_time;
    s2_d.np_neg        = s1_q.next_pts[TIME_W-1];
    s2_d.x8            = np_mag[TIME_W-1:3];
  end

  // stage b: nominal duration, clock distance check, reciprocal products
  always_comb begin
    clk_mag = s2_q.clk_diff[DIFF_W-1] ? (~s2_q.clk_diff + DIFF_W'(1)) : s2_q.clk_diff;
    s3_d.frame_ready      = s2_q.frame_ready;
    s3_d.pts_valid        = s2_q.pts_valid;
    s3_d.ctl.clocks_valid = s2_q.clocks_valid;
    s3_d.ctl.clk_near     = clk_mag < {{(DIFF_W-DUR_W){1'b0}}, cfg_q.frame_dur_limit};
    if (!s2_q.ser_eq) begin
      s3_d.nominal = '0;
    end else if (s2_q.pts_valid && (s2_q.pts_diff > $signed(DIFF_W'(0)))
                 && (s2_q.pts_diff <= $signed({{(DIFF_W-DUR_W){1'b0}},
                                               cfg_q.frame_dur_limit}))) begin
      s3_d.nominal = s2_q.pts_diff[DUR_W-1:0];
    end else begin
      s3_d.nominal = s2_q.prev_duration;
    end
    s3_d.clk_diff = s2_q.clk_diff;
    s3_d.now      = s2_q.now;
    s3_d.np_neg   = s2_q.np_neg;
    s3_d.p_hh     = 43'(s2_q.x8[X8_W-1:24] * RECIP_125[RECIP_W-1:24]);
    s3_d.p_hl     = 45'(s2_q.x8[X8_W-1:24] * RECIP_125[23:0]);
    s3_d.p_lh     = 46'(s2_q.x8[23:0] * RECIP_125[RECIP_W-1:24]);
    s3_d.p_ll     = 48'(s2_q.x8[23:0] * RECIP_125[23:0]);
  end

  // stage c: delay correction toward the audio clock, quotient by 1000
  avsfp_skew u_skew (
    .cfg_i      (cfg_q),
    .nominal_i  (s3_q.nominal),
    .clk_diff_i (s3_q.clk_diff),
    .ctl_i      (s3_q.ctl),
    .delay_o    (skew_delay)
  );

  always_comb begin
    prod_sum = 92'({s3_q.p_hh, 48'b0}) + 92'({s3_q.p_hl, 24'b0})
             + 92'({s3_q.p_lh, 24'b0}) + 92'(s3_q.p_ll);
    s4_d.frame_ready = s3_q.frame_ready;
    s4_d.pts_valid   = s3_q.pts_valid;
    s4_d.delay       = skew_delay;
    s4_d.now         = s3_q.now;
    s4_d.np_neg      = s3_q.np_neg;
    s4_d.quo         = prod_sum[RECIP_SH+QUO_W-1:RECIP_SH];
  end

  // stage d: delay minus now ahead of the timer add, signed milliseconds
  always_comb begin
    s5_d.frame_ready = s4_q.frame_ready;
    s5_d.pts_valid   = s4_q.pts_valid;
    s5_d.delay       = s4_q.delay;
    s5_d.dn          = $signed({{(DIFF_W-DUR_W){1'b0}}, s4_q.delay})
                     - $signed({s4_q.now[TIME_W-1], s4_q.now});
    s5_d.now         = s4_q.now;
    s5_d.ms          = s4_q.np_neg ? -$signed({1'b0, s4_q.quo}) : $signed({1'b0, s4_q.quo});
  end

  // stage e: compare against the frame timer and build the result item
  always_comb begin
    gap     = $signed({{2{timer_q[TIME_W-1]}}, timer_q}) + $signed({s5_q.dn[DIFF_W-1], s5_q.dn});
    due     = timer_q + {{(TIME_W-DUR_W){1'b0}}, s5_q.delay};
    not_due = gap > $signed(50'(0));
    late    = (s5_q.delay != '0) && (gap < -$signed({30'b0, cfg_q.sync_threshold_max}));

    out_d                  = '0;
    out_d.wait_us          = cfg_q.refresh_period;
    if (s5_q.frame_ready) begin
      out_d.target_delay = s5_q.delay;
      if (not_due) begin
        if (gap < $signed({30'b0, cfg_q.refresh_period})) begin
          out_d.wait_us = gap[THR_W-1:0];
        end
      end else begin
        out_d.advance = 1'b1;
        if (s5_q.pts_valid) begin
          out_d.shown_time_ms    = s5_q.ms;
          out_d.shown_time_valid = 1'b1;
        end
      end
    end

    timer_d = timer_q;
    if (e_fire && out_d.advance) begin
      timer_d = late ? s5_q.now : $signed(due);
    end
  end

  // frame timer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q <= '0;
    end else begin
      timer_q <= timer_d;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (rdy1)    s1_q  <= in_item_t'(s_axis_tdata);
    if (rdy2)    s2_q  <= s2_d;
    if (rdy3)    s3_q  <= s3_d;
    if (rdy4)    s4_q  <= s4_d;
    if (rdy5)    s5_q  <= s5_d;
    if (out_rdy) out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // checks
  `AVSFP_ASSERT_IMP(a_adv_wait, out_valid_q && out_q.advance, out_q.wait_us == cfg_q.refresh_period, "advancing item must wait one refresh period")
  `AVSFP_ASSERT_IMP(a_shown_adv, out_valid_q && out_q.shown_time_valid, out_q.advance, "shown time without advance")
  `AVSFP_ASSERT_NXT(a_timer_hold, !e_fire, $stable(timer_q), "frame timer moved without an item")

endmodule
